### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the reservation table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irt assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irt assertion failed");

`endif

### hw/rtl/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Command and status codes, controller states and the control/status
// bundles shared by the reservation table controller and datapath.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_BOOK   = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_LIST   = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_BOOKED    = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_FULL      = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_LISTED    = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;       // latch the incoming word
        logic    scan_start;    // rewind the read pointer, clear hit/best
        logic    scan_en;       // read and compare entries
        logic    shift_start;   // point reads just past the matched entry
        logic    shift_en;      // read and move entries down one place
        logic    load_out;      // load the result register
        logic    book_write;    // store the booked slot, bump the count
        logic    cancel_commit; // drop the count after a shift
        logic    list_advance;  // remember the slot just listed
        status_t out_status;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic scan_done;
        logic hit;
        logic full;
        logic empty;
        logic list_last;
        logic out_free;
    } dp_stat_t;

endpackage

### hw/rtl/irt_ctrl.sv
// ----------------------------------------------------------------------------
// irt_ctrl
// Controller for the reservation table: sequences the scan, the shift after
// a cancel, the per-slot listing passes and the result hand-off.
// ----------------------------------------------------------------------------
module irt_ctrl
    import irt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  cmd_t     in_cmd,
    input  dp_stat_t stat,
    output logic     s_tready,
    output ctl_cmd_t ctl
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;

        // pick the result code from the command and the scan outcome
        case (stat.cmd)
            CMD_BOOK:
            begin
                if (stat.hit)
                    ctl.out_status = ST_OVERLAP;
                else if (stat.full)
                    ctl.out_status = ST_FULL;
                else
                    ctl.out_status = ST_BOOKED;
            end
            CMD_CANCEL:
                ctl.out_status = stat.hit ? ST_CANCELLED : ST_NOTFOUND;
            default:
                ctl.out_status = stat.empty ? ST_EMPTY : ST_LISTED;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                // unused command code is dropped without a result
                if (s_tvalid && in_cmd != CMD_RSVD)
                begin
                    ctl.capture    = 1'b1;
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.cmd == CMD_CANCEL && stat.hit)
                    begin
                        ctl.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SHIFT:
            begin
                ctl.shift_en = 1'b1;
                if (stat.scan_done)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                    case (stat.cmd)
                        CMD_BOOK:
                            ctl.book_write = !stat.hit && !stat.full;
                        CMD_CANCEL:
                            ctl.cancel_commit = stat.hit;
                        default:
                        begin
                            if (!stat.empty)
                            begin
                                ctl.list_advance = 1'b1;
                                // run another pass for the next slot in order
                                if (!stat.list_last)
                                begin
                                    ctl.scan_start = 1'b1;
                                    state_next     = S_SCAN;
                                end
                            end
                        end
                    endcase
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### hw/rtl/irt_datapath.sv
// ----------------------------------------------------------------------------
// irt_datapath
// Entry memory, scan pipeline (one entry per cycle), overlap / match /
// next-in-order compare stage, shift write-back and the result register.
// ----------------------------------------------------------------------------
module irt_datapath
    import irt_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 in_cmd,
    input  logic [TIME_BITS-1:0] in_start,
    input  logic [TIME_BITS-1:0] in_end,
    input  logic [TIME_BITS-1:0] in_min,
    input  logic [TIME_BITS-1:0] in_max,
    input  ctl_cmd_t             ctl,
    output dp_stat_t             stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output status_t              out_status,
    output logic [TIME_BITS-1:0] out_start,
    output logic [TIME_BITS-1:0] out_end,
    output logic [TIME_BITS-1:0] out_min,
    output logic [TIME_BITS-1:0] out_max,
    output logic                 out_last
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = 4 * TIME_BITS;

    // Entry memory: {max, min, end, start}, packed in booking order
    logic [EW-1:0] entry_mem [SLOTS];

    cmd_t                 cmd_reg,  cmd_next;
    logic [TIME_BITS-1:0] st_reg,   st_next;
    logic [TIME_BITS-1:0] en_reg,   en_next;
    logic [TIME_BITS-1:0] mn_reg,   mn_next;
    logic [TIME_BITS-1:0] mx_reg,   mx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [EW-1:0]        rd_data_reg;
    logic                 hit_reg, hit_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 best_vld_reg, best_vld_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    logic [EW-1:0]        best_data_reg, best_data_next;
    logic                 prev_vld_reg, prev_vld_next;
    logic [TIME_BITS-1:0] prev_start_reg, prev_start_next;
    logic [IW-1:0]        prev_idx_reg, prev_idx_next;
    logic [CW-1:0]        emit_cnt_reg, emit_cnt_next;
    logic                 out_vld_reg, out_vld_next;
    status_t              out_status_reg, out_status_next;
    logic [EW-1:0]        out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [TIME_BITS-1:0] e_start;
    logic [TIME_BITS-1:0] e_end;
    logic                 overlap;
    logic                 after_prev;
    logic                 take;
    logic                 list_last;

    assign e_start = rd_data_reg[TIME_BITS-1:0];
    assign e_end   = rd_data_reg[2*TIME_BITS-1:TIME_BITS];

    // Read issue: one entry a cycle until the pointer reaches the count
    assign rd_en   = (ctl.scan_en || ctl.shift_en) && (rd_ptr_reg < count_reg);
    assign rd_addr = rd_ptr_reg[IW-1:0];

    // Write: booked slot at the tail, or move an entry down one place
    assign wr_en   = ctl.book_write || (ctl.shift_en && cmp_vld_reg);
    assign wr_addr = ctl.book_write ? count_reg[IW-1:0] : (cmp_idx_reg - IW'(1));
    assign wr_data = ctl.book_write ? {mx_reg, mn_reg, en_reg, st_reg} : rd_data_reg;

    // Compare stage terms
    assign overlap    = (e_start <= st_reg) && (e_end > st_reg);
    assign after_prev = !prev_vld_reg || (e_start > prev_start_reg) ||
                        ((e_start == prev_start_reg) && (cmp_idx_reg > prev_idx_reg));
    assign take       = after_prev &&
                        (!best_vld_reg || (e_start < best_data_reg[TIME_BITS-1:0]));
    assign list_last  = (emit_cnt_reg + CW'(1)) == count_reg;

    // Status to the controller
    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.scan_done = (rd_ptr_reg == count_reg) && !cmp_vld_reg;
        stat.hit       = hit_reg;
        stat.full      = count_reg == CW'(SLOTS);
        stat.empty     = count_reg == '0;
        stat.list_last = list_last;
        stat.out_free  = !out_vld_reg || out_ready;
    end

    // Memory read and write ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= entry_mem[rd_addr];
        if (wr_en)
            entry_mem[wr_addr] <= wr_data;
    end

    // Next-state logic for the datapath registers
    always_comb
    begin
        cmd_next        = cmd_reg;
        st_next         = st_reg;
        en_next         = en_reg;
        mn_next         = mn_reg;
        mx_next         = mx_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        cmp_vld_next    = rd_en;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_data_next  = best_data_reg;
        prev_vld_next   = prev_vld_reg;
        prev_start_next = prev_start_reg;
        prev_idx_next   = prev_idx_reg;
        emit_cnt_next   = emit_cnt_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        // latch the incoming word and restart the listing order
        if (ctl.capture)
        begin
            cmd_next      = in_cmd;
            st_next       = in_start;
            en_next       = in_end;
            mn_next       = in_min;
            mx_next       = in_max;
            prev_vld_next = 1'b0;
            emit_cnt_next = '0;
        end

        // advance the read pointer
        if (ctl.scan_start)
            rd_ptr_next = '0;
        else if (ctl.shift_start)
            rd_ptr_next = CW'(hit_idx_reg) + CW'(1);
        else if (rd_en)
            rd_ptr_next = rd_ptr_reg + CW'(1);

        if (rd_en)
            cmp_idx_next = rd_addr;

        // compare stage
        if (ctl.scan_start)
        begin
            hit_next      = 1'b0;
            best_vld_next = 1'b0;
        end
        else if (ctl.scan_en && cmp_vld_reg)
        begin
            case (cmd_reg)
                CMD_BOOK:
                begin
                    if (overlap)
                        hit_next = 1'b1;
                end
                CMD_CANCEL:
                begin
                    if (!hit_reg && e_start == st_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                    end
                end
                CMD_LIST:
                begin
                    if (take)
                    begin
                        best_vld_next  = 1'b1;
                        best_idx_next  = cmp_idx_reg;
                        best_data_next = rd_data_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // table count
        if (ctl.book_write)
            count_next = count_reg + CW'(1);
        else if (ctl.cancel_commit)
            count_next = count_reg - CW'(1);

        // remember the slot just listed
        if (ctl.list_advance)
        begin
            prev_vld_next   = 1'b1;
            prev_start_next = best_data_reg[TIME_BITS-1:0];
            prev_idx_next   = best_idx_reg;
            emit_cnt_next   = emit_cnt_reg + CW'(1);
        end

        // result register
        if (ctl.load_out)
        begin
            out_vld_next    = 1'b1;
            out_status_next = ctl.out_status;
            if (ctl.out_status == ST_LISTED)
            begin
                out_data_next = best_data_reg;
                out_last_next = list_last;
            end
            else
            begin
                out_data_next = EW'(st_reg);
                out_last_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= CMD_BOOK;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            best_vld_reg <= 1'b0;
            prev_vld_reg <= 1'b0;
            emit_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            cmd_reg      <= cmd_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            cmp_vld_reg  <= cmp_vld_next;
            hit_reg      <= hit_next;
            best_vld_reg <= best_vld_next;
            prev_vld_reg <= prev_vld_next;
            emit_cnt_reg <= emit_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        st_reg         <= st_next;
        en_reg         <= en_next;
        mn_reg         <= mn_next;
        mx_reg         <= mx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        best_idx_reg   <= best_idx_next;
        best_data_reg  <= best_data_next;
        prev_start_reg <= prev_start_next;
        prev_idx_reg   <= prev_idx_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_start  = out_data_reg[TIME_BITS-1:0];
    assign out_end    = out_data_reg[2*TIME_BITS-1:TIME_BITS];
    assign out_min    = out_data_reg[3*TIME_BITS-1:2*TIME_BITS];
    assign out_max    = out_data_reg[4*TIME_BITS-1:3*TIME_BITS];
    assign out_last   = out_last_reg;

endmodule

### hw/rtl/interval_reservation_table.sv
// Operation: book and cancel scan every stored entry through the entry memory's one
//   read port before they answer; a cancel that hits then moves each entry behind the
//   removed slot down one place; list runs one scan pass for each slot that it gives.
// Throughput: one word at a time; the next word is taken once the last result
//   is in the output register. Reset: control cleared, table empty, no clear pass.
// ----------------------------------------------------------------------------
// interval_reservation_table
// Bounded table of reserved time slots with overlap-checked booking, cancel by
// start and a listing sorted by start, over streaming slave/master ports.
// ----------------------------------------------------------------------------
module interval_reservation_table
    import irt_pkg::*;
#(
    parameter int  SLOTS     = 16,
    parameter int  TIME_BITS = 10,
    localparam int DATA_W    = ((4 * TIME_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,  // slot start, slot end, min stay, max stay
    input  logic [CMD_W-1:0]    s_tuser,  // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,  // slot start, slot end, min stay, max stay
    output logic [STATUS_W-1:0] m_tuser,  // status
    output logic                m_tlast   // last
);

    ctl_cmd_t             ctl;
    dp_stat_t             stat;
    cmd_t                 in_cmd;
    status_t              out_status;
    logic [TIME_BITS-1:0] out_start;
    logic [TIME_BITS-1:0] out_end;
    logic [TIME_BITS-1:0] out_min;
    logic [TIME_BITS-1:0] out_max;

    assign in_cmd = cmd_t'(s_tuser);

    irt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_cmd   (in_cmd),
        .stat     (stat),
        .s_tready (s_tready),
        .ctl      (ctl)
    );

    irt_datapath #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_cmd     (in_cmd),
        .in_start   (s_tdata[TIME_BITS-1:0]),
        .in_end     (s_tdata[2*TIME_BITS-1:TIME_BITS]),
        .in_min     (s_tdata[3*TIME_BITS-1:2*TIME_BITS]),
        .in_max     (s_tdata[4*TIME_BITS-1:3*TIME_BITS]),
        .ctl        (ctl),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_start  (out_start),
        .out_end    (out_end),
        .out_min    (out_min),
        .out_max    (out_max),
        .out_last   (m_tlast)
    );

    // Pack the result word, pad bits zero
    assign m_tdata = DATA_W'({out_max, out_min, out_end, out_start});
    assign m_tuser = out_status;

endmodule

### hw/rtl/irt_checker.sv
// ----------------------------------------------------------------------------
// irt_checker
// Port-level checks on the reservation table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irt_checker
    import irt_pkg::*;
#(
    parameter int  TIME_BITS = 10,
    localparam int DATA_W    = ((4 * TIME_BITS + 7) / 8) * 8
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [CMD_W-1:0]    s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [DATA_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0] m_tuser,
    input logic                m_tlast
);

    // A stalled result word holds its contents
    `IRT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Only listed slots can be followed by more results of the same word
    `IRT_ASSERT_NOW(a_single_last, clk, rst_n, m_tvalid && m_tuser != ST_LISTED, m_tlast)

    // Non-listing results carry zero end and durations
    `IRT_ASSERT_NOW(a_zero_fields, clk, rst_n, m_tvalid && m_tuser != ST_LISTED, m_tdata[4*TIME_BITS-1:TIME_BITS] == '0)

    // A real command keeps the input side busy in the cycle after it is taken
    `IRT_ASSERT_NEXT(a_busy_after, clk, rst_n, s_tvalid && s_tready && s_tuser != CMD_RSVD, !s_tready)

endmodule

bind interval_reservation_table irt_checker #(
    .TIME_BITS (TIME_BITS)
) u_irt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
